[sv/sam_pkg.sv]
// Shared types and constants for the sensor alert monitor.
// No dependencies; the interface and design files refer to this package by scoped names.
package sam_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned GasW     = 16;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAS_SET     = 3'd0,
    REG_GAS_CLEAR   = 3'd1,
    REG_COOLDOWN    = 3'd2,
    REG_BATT_LOW    = 3'd3,
    REG_BATT_CLEAR  = 3'd4
  } cfg_reg_e;

  localparam logic [GasW-1:0]  GasSetRst    = 16'd4800;
  localparam logic [GasW-1:0]  GasClearRst  = 16'd4480;
  localparam logic [TimeW-1:0] CooldownRst  = 32'd60000;
  localparam logic [PctW-1:0]  BattLowRst   = 7'd20;
  localparam logic [PctW-1:0]  BattClearRst = 7'd30;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [GasW-1:0]  gas_level;
    logic             door_open;
    logic             power_source;
    logic [PctW-1:0]  battery_percent;
  } in_item_t;

  typedef struct packed {
    logic gas_alert;
    logic door_alert;
    logic power_alert;
    logic power_to_grid;
    logic battery_alert;
  } out_item_t;

  typedef struct packed {
    logic [GasW-1:0]  gas_set_level;
    logic [GasW-1:0]  gas_clear_level;
    logic [TimeW-1:0] cooldown_ms;
    logic [PctW-1:0]  battery_low_pct;
    logic [PctW-1:0]  battery_clear_pct;
  } cfg_t;

endpackage

[sv/sam_if.sv]
// Valid/ready channel interfaces for check items and alert results.
// Depends on sam_pkg for the payload types.
interface sam_in_if;
  logic               valid;
  logic               ready;
  sam_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sam_out_if;
  logic               valid;
  logic               ready;
  sam_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/sensor_alert_monitor_top.sv]
// Channel   | dir | handshake    | payload
// in_i      | in  | valid/ready  | now_ms, gas_level, door_open, power_source, battery_percent
// out_i     | out | valid/ready  | gas/door/power alerts, power_to_grid, battery_alert
// cfg_*     | in  | write enable | cfg_idx_i selects register, cfg_wdata_i data
//
// One item per cycle sustained while out_i accepts results; a result passes through the input
// register, then the result register. Alarm state updates as an item moves
// from the input register into the result register. A stalled result holds both
// registers; in_i.ready stays high while the input register can drain.
// Reset restores register defaults, clears latches and times, power source unknown.
// Depends on sam_pkg, sam_if, sam_cfg_regs and sam_core.
module sensor_alert_monitor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sam_in_if.sink                       in_i,
  sam_out_if.source                    out_i,
  input  logic                         cfg_we_i,
  input  logic [sam_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sam_pkg::CfgDataW-1:0] cfg_wdata_i
);

  sam_pkg::cfg_t      cfg;
  sam_pkg::in_item_t  item_q;
  sam_pkg::out_item_t res, res_q;
  logic               item_vld_q, item_vld_d;
  logic               res_vld_q, res_vld_d;
  logic               out_adv, step, in_xfer;

  assign out_adv    = !res_vld_q || out_i.ready;
  assign step       = item_vld_q && out_adv;
  assign in_i.ready = !item_vld_q || out_adv;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign item_vld_d = in_xfer || (item_vld_q && !out_adv);
  assign res_vld_d  = out_adv ? item_vld_q : 1'b1;

  sam_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sam_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_i.data;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_i.valid = res_vld_q;
  assign out_i.data  = res_q;

endmodule

[sv/sam_cfg_regs.sv]
// Configuration register file: thresholds and cooldown, write-only.
// Depends on sam_pkg.
module sam_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sam_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sam_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output sam_pkg::cfg_t                 cfg_o
);

  sam_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gas_set_level     <= sam_pkg::GasSetRst;
      cfg_q.gas_clear_level   <= sam_pkg::GasClearRst;
      cfg_q.cooldown_ms       <= sam_pkg::CooldownRst;
      cfg_q.battery_low_pct   <= sam_pkg::BattLowRst;
      cfg_q.battery_clear_pct <= sam_pkg::BattClearRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sam_pkg::REG_GAS_SET:    cfg_q.gas_set_level     <= cfg_wdata_i[sam_pkg::GasW-1:0];
        sam_pkg::REG_GAS_CLEAR:  cfg_q.gas_clear_level   <= cfg_wdata_i[sam_pkg::GasW-1:0];
        sam_pkg::REG_COOLDOWN:   cfg_q.cooldown_ms       <= cfg_wdata_i[sam_pkg::TimeW-1:0];
        sam_pkg::REG_BATT_LOW:   cfg_q.battery_low_pct   <= cfg_wdata_i[sam_pkg::PctW-1:0];
        sam_pkg::REG_BATT_CLEAR: cfg_q.battery_clear_pct <= cfg_wdata_i[sam_pkg::PctW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/sam_core.sv]
// Alert decision logic and alarm state (latches, last-alert times, power source).
// Depends on sam_pkg. State advances only on step_i.
module sam_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sam_pkg::in_item_t  item_i,
  input  sam_pkg::cfg_t      cfg_i,
  output sam_pkg::out_item_t res_o
);

  logic                      gas_latched_q, gas_latched_d;
  logic                      door_latched_q, door_latched_d;
  logic                      batt_latched_q, batt_latched_d;
  logic                      pwr_known_q, pwr_known_d;
  logic                      pwr_src_q, pwr_src_d;
  logic [sam_pkg::TimeW-1:0] gas_time_q, gas_time_d;
  logic [sam_pkg::TimeW-1:0] door_time_q, door_time_d;
  logic [sam_pkg::TimeW-1:0] pwr_time_q, pwr_time_d;

  logic [sam_pkg::TimeW-1:0] gas_dt, door_dt, pwr_dt;
  logic gas_cool, door_cool, pwr_cool;
  logic gas_fire, door_fire, pwr_fire, batt_fire;

  always_comb begin
    // elapsed times wrap modulo 2^32
    gas_dt    = item_i.now_ms - gas_time_q;
    door_dt   = item_i.now_ms - door_time_q;
    pwr_dt    = item_i.now_ms - pwr_time_q;
    gas_cool  = gas_dt > cfg_i.cooldown_ms;
    door_cool = door_dt > cfg_i.cooldown_ms;
    pwr_cool  = pwr_dt > cfg_i.cooldown_ms;

    gas_fire  = (item_i.gas_level > cfg_i.gas_set_level) && !gas_latched_q && gas_cool;
    door_fire = item_i.door_open && !door_latched_q && door_cool;
    pwr_fire  = !(pwr_known_q && (pwr_src_q == item_i.power_source)) && pwr_cool;
    // a power alert restamps the shared timer, so elapsed is zero for battery
    batt_fire = (item_i.battery_percent <= cfg_i.battery_low_pct) && !batt_latched_q &&
                pwr_cool && !pwr_fire;

    gas_latched_d  = (gas_latched_q || gas_fire) &&
                     !(item_i.gas_level <= cfg_i.gas_clear_level);
    door_latched_d = (door_latched_q || door_fire) && item_i.door_open;
    batt_latched_d = (batt_latched_q || batt_fire) &&
                     !(item_i.battery_percent >= cfg_i.battery_clear_pct);
    pwr_known_d    = pwr_known_q || pwr_fire;
    pwr_src_d      = pwr_fire ? item_i.power_source : pwr_src_q;
    gas_time_d     = gas_fire ? item_i.now_ms : gas_time_q;
    door_time_d    = door_fire ? item_i.now_ms : door_time_q;
    pwr_time_d     = (pwr_fire || batt_fire) ? item_i.now_ms : pwr_time_q;

    res_o.gas_alert     = gas_fire;
    res_o.door_alert    = door_fire;
    res_o.power_alert   = pwr_fire;
    res_o.power_to_grid = pwr_fire && item_i.power_source;
    res_o.battery_alert = batt_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gas_latched_q  <= 1'b0;
      door_latched_q <= 1'b0;
      batt_latched_q <= 1'b0;
      pwr_known_q    <= 1'b0;
      pwr_src_q      <= 1'b0;
      gas_time_q     <= '0;
      door_time_q    <= '0;
      pwr_time_q     <= '0;
    end else if (step_i) begin
      gas_latched_q  <= gas_latched_d;
      door_latched_q <= door_latched_d;
      batt_latched_q <= batt_latched_d;
      pwr_known_q    <= pwr_known_d;
      pwr_src_q      <= pwr_src_d;
      gas_time_q     <= gas_time_d;
      door_time_q    <= door_time_d;
      pwr_time_q     <= pwr_time_d;
    end
  end

endmodule

[sv/sam_checker.sv]
// Port-level checks on the alert results of the sensor alert monitor, plus bind.
// Depends on sam_pkg types only through the bound port expressions.
module sam_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic gas_alert_i,
  input logic door_alert_i,
  input logic power_alert_i,
  input logic power_to_grid_i,
  input logic battery_alert_i
);

  logic out_xfer;
  assign out_xfer = out_valid_i && out_ready_i;

  // power alert restamps the shared timer, so battery cannot fire with it
  a_pwr_batt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(power_alert_i && battery_alert_i))
    else $error("power and battery alerts in one result");

  a_grid_only_with_alert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !power_alert_i) |-> !power_to_grid_i)
    else $error("power_to_grid set without power alert");

  // back-to-back power alerts must report alternating sources
  a_pwr_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && power_alert_i && $past(out_xfer && power_alert_i))
      |-> (power_to_grid_i != $past(power_to_grid_i)))
    else $error("consecutive power alerts to the same source");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable({gas_alert_i, door_alert_i, power_alert_i,
                               power_to_grid_i, battery_alert_i})))
    else $error("result changed during stall");

endmodule

bind sensor_alert_monitor_top sam_checker u_sam_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_i.valid),
  .out_ready_i     (out_i.ready),
  .gas_alert_i     (out_i.data.gas_alert),
  .door_alert_i    (out_i.data.door_alert),
  .power_alert_i   (out_i.data.power_alert),
  .power_to_grid_i (out_i.data.power_to_grid),
  .battery_alert_i (out_i.data.battery_alert)
);
